// ----- src/smed_pkg.sv -----
`default_nettype none
package smed_pkg;

  localparam int ValW   = 32;
  localparam int CountW = 7;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_DRAIN,
    ST_SUM,
    ST_FIN
  } smed_state_t;

  typedef struct packed {
    logic                   ins;
    logic                   shf;
    logic signed [ValW-1:0] x;
  } smed_ctl_t;

endpackage
`default_nettype wire

// ----- src/smed_cell.sv -----
`default_nettype none
module smed_cell #(
  parameter int IDX = 0,
  parameter int CW  = 7
) (
  input  wire logic                           clk,
  input  wire smed_pkg::smed_ctl_t            ctl,
  input  wire logic [CW-1:0]                  count,
  input  wire logic                           gt_left,
  input  wire logic signed [smed_pkg::ValW-1:0] v_left,
  input  wire logic signed [smed_pkg::ValW-1:0] v_right,
  output logic                                gt,
  output logic signed [smed_pkg::ValW-1:0]    v
);
  import smed_pkg::*;

  logic signed [ValW-1:0] v_r;
  logic signed [ValW-1:0] v_nxt;
  logic                   occ;
  logic                   prev_occ;
  logic                   take_x;

  // occupied cells are those below the fill count
  assign occ      = count > CW'(IDX);
  assign prev_occ = count >= CW'(IDX);
  assign gt       = occ && (v_r > ctl.x);
  assign take_x   = !gt_left && (gt || !occ) && prev_occ;
  assign v        = v_r;

  always_comb begin
    v_nxt = v_r;
    if (ctl.shf) begin
      v_nxt = v_right;
    end else if (ctl.ins) begin
      if (gt_left) begin
        v_nxt = v_left;
      end else if (take_x) begin
        v_nxt = ctl.x;
      end
    end
  end

  always_ff @(posedge clk) begin
    v_r <= v_nxt;
  end

endmodule
`default_nettype wire

// ----- src/stream_median_select.sv -----
// channel  | dir | tdata (low bit up)                 | tuser     | tlast
// in_      | in  | value[31:0]                        | -         | last
// out_     | out | median[31:0], count[38:32], pad 0  | overflow  | -
//
// loading takes one word per cycle in the load state: every cell of the
// chain compares and inserts in parallel. after the last word the chain
// shifts toward cell 0 until the upper middle value reaches cell 0, then a
// sum state adds the two middle values and a final state halves the sum
// into the output register. the output register lets the next set load
// while a result waits. reset clears the fill count, the overflow flag, the
// control state and the output valid; cell contents are not reset.
`default_nettype none
module stream_median_select #(
  parameter int CAPACITY = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // value[31:0]
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // median[31:0], count[38:32], zero[39]
  output logic [0:0]       out_tuser   // overflow[0]
);
  import smed_pkg::*;

  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int CXW = (CW > CountW) ? CW : CountW;

  smed_state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          drop_r, drop_nxt;
  logic [CW-1:0] sh_r, sh_nxt;
  logic signed [ValW-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic signed [ValW:0]   sum_r, sum_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic signed [ValW-1:0] out_med_r, out_med_nxt;
  logic [CountW-1:0]      out_cnt_r, out_cnt_nxt;
  logic          out_ovf_r, out_ovf_nxt;

  smed_ctl_t     ctl;
  logic          full;
  logic          acc;
  logic          fin_load;
  logic [CW-1:0] lo_idx, hi_idx;
  logic [CXW-1:0] cnt_ext;
  logic signed [ValW:0] sum_adj;
  logic signed [ValW-1:0] val [CAPACITY];
  logic                   gtv [CAPACITY];

  assign full     = count_r == CW'(CAPACITY);
  assign acc      = in_tvalid && in_tready;
  assign fin_load = (state_r == ST_FIN) && (!out_valid_r || out_tready);
  assign lo_idx   = (count_r - CW'(1)) >> 1;
  assign hi_idx   = count_r >> 1;
  assign cnt_ext  = CXW'(count_r);
  assign sum_adj  = sum_r + {{ValW{1'b0}}, sum_r[ValW]};

  // compare-and-insert chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                   gl;
    logic signed [ValW-1:0] vl, vr;
    if (i == 0) begin : g_head
      assign gl = 1'b0;
      assign vl = '0;
    end else begin : g_body
      assign gl = gtv[i-1];
      assign vl = val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign vr = val[i];
    end else begin : g_mid
      assign vr = val[i+1];
    end
    smed_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .count   (count_r),
      .gt_left (gl),
      .v_left  (vl),
      .v_right (vr),
      .gt      (gtv[i]),
      .v       (val[i])
    );
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (acc && in_tlast) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (sh_r == hi_idx) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: state_nxt = ST_FIN;
      ST_FIN: begin
        if (fin_load) begin
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    ctl.ins   = 1'b0;
    ctl.shf   = 1'b0;
    ctl.x     = $signed(in_tdata);
    unique case (state_r)
      ST_LOAD: begin
        in_tready = 1'b1;
        ctl.ins   = in_tvalid && !full;
      end
      ST_DRAIN: ctl.shf = 1'b1;
      ST_SUM:   ;
      ST_FIN:   ;
      default:  ;
    endcase
  end

  always_comb begin
    count_nxt     = count_r;
    drop_nxt      = drop_r;
    sh_nxt        = sh_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    sum_nxt       = sum_r;
    out_med_nxt   = out_med_r;
    out_cnt_nxt   = out_cnt_r;
    out_ovf_nxt   = out_ovf_r;
    out_valid_nxt = out_valid_r && !out_tready;
    if (acc) begin
      sh_nxt = '0;
      if (full) begin
        drop_nxt = 1'b1;
      end else begin
        count_nxt = count_r + CW'(1);
      end
    end
    if (state_r == ST_DRAIN) begin
      sh_nxt = sh_r + CW'(1);
      if (sh_r == lo_idx) begin
        lo_nxt = val[0];
      end
      if (sh_r == hi_idx) begin
        hi_nxt = val[0];
      end
    end
    if (state_r == ST_SUM) begin
      sum_nxt = {lo_r[ValW-1], lo_r} + {hi_r[ValW-1], hi_r};
    end
    if (fin_load) begin
      out_med_nxt   = sum_adj[ValW:1];
      out_cnt_nxt   = cnt_ext[CountW-1:0];
      out_ovf_nxt   = drop_r;
      out_valid_nxt = 1'b1;
      count_nxt     = '0;
      drop_nxt      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      drop_r      <= 1'b0;
      sh_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      drop_r      <= drop_nxt;
      sh_r        <= sh_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    sum_r     <= sum_nxt;
    out_med_r <= out_med_nxt;
    out_cnt_r <= out_cnt_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_cnt_r, out_med_r};
  assign out_tuser  = out_ovf_r;

endmodule
`default_nettype wire

// ----- src/smed_chk.sv -----
`default_nettype none
module smed_chk #(
  parameter int CAPACITY = 64
) (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        in_tlast,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata,
  input wire logic [0:0]  out_tuser
);
  localparam logic [6:0] CapCnt = 7'(CAPACITY);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed under stall");

  // end of a set stops intake while the chain drains
  a_last_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input taken right after last word");

  // overflow only with a full store
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[38:32] == CapCnt)
    else $error("overflow without full count");

  // count never zero below wrap width
  a_cnt_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (CAPACITY < 128) |-> out_tdata[38:32] != 7'd0)
    else $error("empty set reported");

  // pad bit stays zero
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[39])
    else $error("pad bit set");

endmodule

bind stream_median_select smed_chk #(
  .CAPACITY (CAPACITY)
) u_smed_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire
